[src/jts_pkg.sv]
package jts_pkg;

   localparam int DEF_MAX_LEXEME = 1024;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

   // token kinds
   localparam logic [3:0] KIND_NONE     = 4'd0;
   localparam logic [3:0] KIND_LBRACE   = 4'd1;
   localparam logic [3:0] KIND_RBRACE   = 4'd2;
   localparam logic [3:0] KIND_LBRACKET = 4'd3;
   localparam logic [3:0] KIND_RBRACKET = 4'd4;
   localparam logic [3:0] KIND_COLON    = 4'd5;
   localparam logic [3:0] KIND_COMMA    = 4'd6;
   localparam logic [3:0] KIND_TRUE     = 4'd7;
   localparam logic [3:0] KIND_STRING   = 4'd10;
   localparam logic [3:0] KIND_NUMBER   = 4'd11;
   localparam logic [3:0] KIND_ERROR    = 4'd12;
   localparam logic [3:0] KIND_END      = 4'd13;

   // characters
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LZ     = 8'h7A;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] CH_LB     = 8'h62;
   localparam logic [7:0] CH_LE     = 8'h65;
   localparam logic [7:0] CH_UE     = 8'h45;
   localparam logic [7:0] CH_LF_    = 8'h66;
   localparam logic [7:0] CH_LN     = 8'h6E;
   localparam logic [7:0] CH_LR     = 8'h72;
   localparam logic [7:0] CH_LT     = 8'h74;

   typedef enum logic [4:0] {
      MODE_START  = 5'b00001,
      MODE_STRING = 5'b00010,
      MODE_ESCAPE = 5'b00100,
      MODE_NUMBER = 5'b01000,
      MODE_IDENT  = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [3:0] kind;
      logic       cv;
      logic [7:0] ch;
   } token_type;

   typedef struct packed {
      token_type tok;
      logic      last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] num;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic token_type tok_char(input logic [7:0] c);
      token_type t;
      t.kind = KIND_NONE;
      t.cv = 1'b1;
      t.ch = c;
      return t;
   endfunction

   function automatic token_type tok_kind(input logic [3:0] k);
      token_type t;
      t.kind = k;
      t.cv = 1'b0;
      t.ch = 8'h00;
      return t;
   endfunction

   // keyword text: 0 true, 1 false, 2 null
   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
      logic [7:0] r;
      r = 8'h00;
      unique case (k)
         2'd0: begin
            unique case (idx)
               3'd0: r = "t";
               3'd1: r = "r";
               3'd2: r = "u";
               3'd3: r = "e";
               default: r = 8'h00;
            endcase
         end
         2'd1: begin
            unique case (idx)
               3'd0: r = "f";
               3'd1: r = "a";
               3'd2: r = "l";
               3'd3: r = "s";
               3'd4: r = "e";
               default: r = 8'h00;
            endcase
         end
         2'd2: begin
            unique case (idx)
               3'd0: r = "n";
               3'd1: r = "u";
               3'd2: r = "l";
               3'd3: r = "l";
               default: r = 8'h00;
            endcase
         end
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] kw_len(input logic [1:0] k);
      logic [2:0] r;
      unique case (k)
         2'd1: r = 3'd5;
         default: r = 3'd4;
      endcase
      return r;
   endfunction

endpackage

[src/jts_scan.sv]
module jts_scan #(
   parameter int MAX_LEXEME = jts_pkg::DEF_MAX_LEXEME
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_in_byte,
   input  logic              req_end_of_text,
   input  logic              fifo_room,
   output jts_pkg::push_type push
);
   import jts_pkg::*;

   localparam int CW = $clog2(MAX_LEXEME);
   localparam logic [CW-1:0] CNT_LAST = CW'(MAX_LEXEME - 1);

   logic          item_valid_ff;
   logic [7:0]    byte_ff;
   logic          eot_ff;
   mode_type      mode_ff, mode_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [2:0]    kw_ff, kw_in;
   logic          consume;

   logic          is_space, is_digit, is_alpha, is_num, is_esc, is_punct;
   logic [3:0]    punct_kind;
   logic [2:0]    kw_first, kw_next;
   logic [3:0]    id_kind;
   logic          ap_ovf;

   logic          st_emit;
   token_type     st_tok;
   mode_type      st_mode;
   logic [CW-1:0] st_cnt;
   logic [2:0]    st_kw;

   logic [1:0]    n;
   token_type     r0, r1;

   function automatic logic [2:0] kw_step(input logic [2:0] base, input logic [CW-1:0] idx,
                                          input logic [7:0] ch);
      logic [2:0] r;
      r = base;
      for (int i = 0; i < 3; i++) begin
         if (idx >= CW'(kw_len(2'(i))) || kw_char(2'(i), idx[2:0]) != ch)
            r[i] = 1'b0;
      end
      return r;
   endfunction

   assign consume   = item_valid_ff && fifo_room;
   assign req_stall = item_valid_ff && !fifo_room;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         byte_ff <= req_in_byte;
         eot_ff  <= req_end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_START;
         cnt_ff  <= '0;
         kw_ff   <= 3'b111;
      end else if (consume) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         kw_ff   <= kw_in;
      end
   end

   // character classes
   always_comb begin
      is_space = byte_ff == CH_SPACE || (byte_ff >= CH_TAB && byte_ff <= CH_CR);
      is_digit = byte_ff >= CH_0 && byte_ff <= CH_9;
      is_alpha = (byte_ff >= CH_LA && byte_ff <= CH_LZ) || (byte_ff >= CH_UA && byte_ff <= CH_UZ);
      is_num   = is_digit || byte_ff == CH_DOT || byte_ff == CH_LE || byte_ff == CH_UE ||
                 byte_ff == CH_PLUS || byte_ff == CH_MINUS;
      is_esc   = byte_ff == CH_QUOTE || byte_ff == CH_BSLASH || byte_ff == CH_SLASH ||
                 byte_ff == CH_LB || byte_ff == CH_LF_ || byte_ff == CH_LN ||
                 byte_ff == CH_LR || byte_ff == CH_LT;
      is_punct   = 1'b1;
      punct_kind = KIND_NONE;
      priority if (byte_ff == CH_LBRACE) punct_kind = KIND_LBRACE;
      else if (byte_ff == CH_RBRACE)     punct_kind = KIND_RBRACE;
      else if (byte_ff == CH_LBRACK)     punct_kind = KIND_LBRACKET;
      else if (byte_ff == CH_RBRACK)     punct_kind = KIND_RBRACKET;
      else if (byte_ff == CH_COLON)      punct_kind = KIND_COLON;
      else if (byte_ff == CH_COMMA)      punct_kind = KIND_COMMA;
      else                               is_punct = 1'b0;
   end

   assign kw_first = kw_step(3'b111, '0, byte_ff);
   assign kw_next  = kw_step(kw_ff, cnt_ff, byte_ff);
   assign ap_ovf   = cnt_ff == CNT_LAST;

   // first keyword that matches over its full length wins
   always_comb begin
      id_kind = KIND_ERROR;
      for (int i = 2; i >= 0; i--) begin
         if (kw_ff[i] && cnt_ff == CW'(kw_len(2'(i))))
            id_kind = KIND_TRUE + 4'(i);
      end
   end

   // byte handled in start state, lexeme count taken as zero
   always_comb begin
      st_emit = 1'b0;
      st_tok  = tok_kind(KIND_NONE);
      st_mode = MODE_START;
      st_cnt  = '0;
      st_kw   = kw_ff;
      priority if (is_space) begin
      end else if (is_punct) begin
         st_emit = 1'b1;
         st_tok  = tok_kind(punct_kind);
      end else if (byte_ff == CH_QUOTE) begin
         st_mode = MODE_STRING;
      end else if (is_digit || byte_ff == CH_MINUS) begin
         st_emit = 1'b1;
         st_tok  = tok_char(byte_ff);
         st_mode = MODE_NUMBER;
         st_cnt  = CW'(1);
      end else if (is_alpha) begin
         st_emit = 1'b1;
         st_tok  = tok_char(byte_ff);
         st_mode = MODE_IDENT;
         st_cnt  = CW'(1);
         st_kw   = kw_first;
      end else begin
         st_emit = 1'b1;
         st_tok  = tok_kind(KIND_ERROR);
      end
   end

   always_comb begin
      n       = 2'd0;
      r0      = tok_kind(KIND_NONE);
      r1      = tok_kind(KIND_NONE);
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      kw_in   = kw_ff;
      if (eot_ff) begin
         mode_in = MODE_START;
         cnt_in  = '0;
         kw_in   = 3'b111;
         if (mode_ff == MODE_START) begin
            n  = 2'd1;
            r0 = tok_kind(KIND_END);
         end else begin
            n  = 2'd2;
            r1 = tok_kind(KIND_END);
            unique case (mode_ff)
               MODE_NUMBER: r0 = tok_kind(KIND_NUMBER);
               MODE_IDENT:  r0 = tok_kind(id_kind);
               default:     r0 = tok_kind(KIND_ERROR);
            endcase
         end
      end else begin
         unique case (mode_ff)
            MODE_STRING, MODE_ESCAPE, MODE_NUMBER, MODE_IDENT: begin
               if (mode_ff == MODE_STRING && byte_ff == CH_QUOTE) begin
                  n       = 2'd1;
                  r0      = tok_kind(KIND_STRING);
                  mode_in = MODE_START;
                  cnt_in  = '0;
               end else if (mode_ff == MODE_STRING && byte_ff == CH_BSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else if ((mode_ff == MODE_ESCAPE && !is_esc) ||
                            (mode_ff == MODE_NUMBER && !is_num) ||
                            (mode_ff == MODE_IDENT && !is_alpha)) begin
                  // run ends; escape failure just reports error
                  n = 2'd1;
                  if (mode_ff == MODE_ESCAPE) begin
                     r0      = tok_kind(KIND_ERROR);
                     mode_in = MODE_START;
                     cnt_in  = '0;
                  end else begin
                     r0      = tok_kind(mode_ff == MODE_NUMBER ? KIND_NUMBER : id_kind);
                     mode_in = st_mode;
                     cnt_in  = st_cnt;
                     kw_in   = st_kw;
                     if (st_emit) begin
                        n  = 2'd2;
                        r1 = st_tok;
                     end
                  end
               end else begin
                  // append lexeme byte, or report an error when the lexeme is full
                  n = 2'd1;
                  if (ap_ovf) begin
                     r0      = tok_kind(KIND_ERROR);
                     mode_in = MODE_START;
                     cnt_in  = '0;
                  end else begin
                     r0     = tok_char(byte_ff);
                     cnt_in = cnt_ff + CW'(1);
                     if (mode_ff == MODE_ESCAPE)
                        mode_in = MODE_STRING;
                     if (mode_ff == MODE_IDENT)
                        kw_in = kw_next;
                  end
               end
            end
            default: begin
               n       = {1'b0, st_emit};
               r0      = st_tok;
               mode_in = st_mode;
               cnt_in  = st_cnt;
               kw_in   = st_kw;
            end
         endcase
      end
   end

   always_comb begin
      push.num         = consume ? n : 2'd0;
      push.first.tok   = r0;
      push.first.last  = n == 2'd1;
      push.second.tok  = r1;
      push.second.last = 1'b1;
   end

endmodule

[src/jts_fifo.sv]
module jts_fifo (
   input  logic              clock,
   input  logic              reset,
   input  jts_pkg::push_type push,
   output logic              fifo_room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output jts_pkg::rsp_type  rsp_data
);
   import jts_pkg::*;

   rsp_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic                 pop;

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // room for the two results one request may give
   assign fifo_room = count_ff <= FIFO_CW'(FIFO_DEPTH - 2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push.num);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + FIFO_CW'(push.num) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0)
         mem_ff[wr_ptr_ff] <= push.first;
      if (push.num == 2'd2)
         mem_ff[wr_ptr_ff + FIFO_AW'(1)] <= push.second;
   end

endmodule

[src/json_token_scanner.sv]
// Requests are registered in the scan stage; their results are written to the
// result queue, which drives the rsp port. Throughput: one request per cycle while
// each gives at most one result and the queue has room for two; a request giving
// two results (run end plus terminating byte) takes two of the 4 queue entries.
// Reset: synchronous, active high; scan state returns to start, queue empties.
module json_token_scanner #(
   parameter int MAX_LEXEME = jts_pkg::DEF_MAX_LEXEME
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_token_kind,
   output logic       rsp_char_valid,
   output logic [7:0] rsp_char_out,
   output logic       rsp_last_of_run
);
   import jts_pkg::*;

   push_type push;
   rsp_type  rsp_data;
   logic     fifo_room;

   jts_scan #(
      .MAX_LEXEME(MAX_LEXEME)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_end_of_text(req_end_of_text),
      .fifo_room      (fifo_room),
      .push           (push)
   );

   jts_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .fifo_room(fifo_room),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   assign rsp_token_kind  = rsp_data.tok.kind;
   assign rsp_char_valid  = rsp_data.tok.cv;
   assign rsp_char_out    = rsp_data.tok.ch;
   assign rsp_last_of_run = rsp_data.last;

endmodule

[src/jts_checker.sv]
module jts_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_token_kind,
   input logic       rsp_char_valid,
   input logic [7:0] rsp_char_out,
   input logic       rsp_last_of_run
);
   import jts_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind) &&
         $stable(rsp_char_valid) && $stable(rsp_char_out) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   // lexeme bytes carry no token, tokens carry no byte
   a_char_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_valid == (rsp_token_kind == KIND_NONE)))
      else $error("lexeme byte and token kind disagree");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_char_out == 8'h00)
      else $error("token result with nonzero byte");

   // end token is always the last result of its request
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_END |-> rsp_last_of_run)
      else $error("end token not last of run");

   // input only backs up when results are waiting
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty result queue");

endmodule

bind json_token_scanner jts_checker u_jts_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_token_kind (rsp_token_kind),
   .rsp_char_valid (rsp_char_valid),
   .rsp_char_out   (rsp_char_out),
   .rsp_last_of_run(rsp_last_of_run)
);

[dv/tb_json_token_scanner.sv]
module tb_json_token_scanner;
   timeunit 1ns;
   timeprecision 1ps;

   import jts_pkg::*;

   localparam int LEX_MAX = DEF_MAX_LEXEME;
   localparam int N_RANDOM = 350;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;

   localparam logic [7:0] CH_NL = 8'h0A;
   localparam logic [7:0] CH_VT = 8'h0B;
   localparam logic [7:0] CH_FF = 8'h0C;
   localparam logic [7:0] CH_SUB = 8'h5F;

   typedef struct packed {
      logic [7:0] ch;
      logic       eot;
   } req_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [3:0] rsp_token_kind;
   logic       rsp_char_valid;
   logic [7:0] rsp_char_out;
   logic       rsp_last_of_run;

   json_token_scanner #(.MAX_LEXEME(LEX_MAX)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_byte(req_in_byte),
      .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_token_kind(rsp_token_kind),
      .rsp_char_valid(rsp_char_valid),
      .rsp_char_out(rsp_char_out),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always #1 clock = ~clock;

   string      kw_word [3] = '{"true", "false", "null"};
   string      num_set = "0123456789.eE+-";
   logic [7:0] blank_set [6] = '{CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
   logic [7:0] esc_set [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LB, CH_LF_, CH_LN, CH_LR,
                               CH_LT};

   req_item_type pending_q [$];
   req_item_type on_bus;
   rsp_type      tokens_due [$];
   token_type    run_toks [$];

   // scanner shadow state
   mode_type   scan_st = MODE_START;
   int         lex_len = 0;
   logic [2:0] kw_live = 3'b111;

   int mismatches = 0;
   int taken = 0;
   int results_seen = 0;
   int quiet = 0;
   int cyc = 0;
   int hold_left = 0;

   task automatic flag_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatches++;
   endtask

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
   endfunction

   function automatic void give(logic [3:0] k, logic cv, logic [7:0] c);
      token_type t;
      t.kind = k;
      t.cv = cv;
      t.ch = cv ? c : 8'h00;
      run_toks.push_back(t);
   endfunction

   function automatic void go_idle();
      scan_st = MODE_START;
      lex_len = 0;
   endfunction

   function automatic void add_char(logic [7:0] c);
      if (lex_len >= LEX_MAX - 1) begin
         give(KIND_ERROR, 1'b0, 8'h00);
         go_idle();
         return;
      end
      if (scan_st == MODE_IDENT)
         for (int i = 0; i < 3; i++)
            if (lex_len >= kw_word[i].len() || kw_word[i][lex_len] != c)
               kw_live[i] = 1'b0;
      lex_len++;
      give(KIND_NONE, 1'b1, c);
   endfunction

   function automatic logic [3:0] word_kind();
      for (int i = 0; i < 3; i++)
         if (kw_live[i] && lex_len == kw_word[i].len())
            return KIND_TRUE + 4'(i);
      return KIND_ERROR;
   endfunction

   function automatic void at_start(logic [7:0] c);
      if (is_blank(c))
         return;
      case (c)
         CH_LBRACE: give(KIND_LBRACE, 1'b0, 8'h00);
         CH_RBRACE: give(KIND_RBRACE, 1'b0, 8'h00);
         CH_LBRACK: give(KIND_LBRACKET, 1'b0, 8'h00);
         CH_RBRACK: give(KIND_RBRACKET, 1'b0, 8'h00);
         CH_COLON:  give(KIND_COLON, 1'b0, 8'h00);
         CH_COMMA:  give(KIND_COMMA, 1'b0, 8'h00);
         CH_QUOTE: begin
            scan_st = MODE_STRING;
            lex_len = 0;
         end
         default: begin
            if (is_digit(c) || c == CH_MINUS) begin
               scan_st = MODE_NUMBER;
               lex_len = 0;
               add_char(c);
            end else if (is_letter(c)) begin
               scan_st = MODE_IDENT;
               lex_len = 0;
               kw_live = 3'b111;
               add_char(c);
            end else begin
               give(KIND_ERROR, 1'b0, 8'h00);
            end
         end
      endcase
   endfunction

   function automatic void scan_request(req_item_type it);
      logic [7:0] c;
      c = it.ch;
      run_toks.delete();
      if (it.eot) begin
         case (scan_st)
            MODE_NUMBER: give(KIND_NUMBER, 1'b0, 8'h00);
            MODE_IDENT:  give(word_kind(), 1'b0, 8'h00);
            MODE_STRING, MODE_ESCAPE: give(KIND_ERROR, 1'b0, 8'h00);
            default: ;
         endcase
         give(KIND_END, 1'b0, 8'h00);
         go_idle();
         kw_live = 3'b111;
      end else begin
         case (scan_st)
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  give(KIND_STRING, 1'b0, 8'h00);
                  go_idle();
               end else if (c == CH_BSLASH) begin
                  scan_st = MODE_ESCAPE;
               end else begin
                  add_char(c);
               end
            end
            MODE_ESCAPE: begin
               if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_LB ||
                   c == CH_LF_ || c == CH_LN || c == CH_LR || c == CH_LT) begin
                  scan_st = MODE_STRING;
                  add_char(c);
               end else begin
                  give(KIND_ERROR, 1'b0, 8'h00);
                  go_idle();
               end
            end
            MODE_NUMBER: begin
               if (is_digit(c) || c == CH_DOT || c == CH_LE || c == CH_UE || c == CH_PLUS ||
                   c == CH_MINUS) begin
                  add_char(c);
               end else begin
                  give(KIND_NUMBER, 1'b0, 8'h00);
                  go_idle();
                  at_start(c);
               end
            end
            MODE_IDENT: begin
               if (is_letter(c)) begin
                  add_char(c);
               end else begin
                  give(word_kind(), 1'b0, 8'h00);
                  go_idle();
                  at_start(c);
               end
            end
            default: begin
               scan_st = MODE_START;
               at_start(c);
            end
         endcase
      end
      foreach (run_toks[i]) begin
         rsp_type r;
         r.tok = run_toks[i];
         r.last = (i == run_toks.size() - 1);
         tokens_due.push_back(r);
      end
   endfunction

   // ---------------- stimulus ----------------

   task automatic push_byte(input logic [7:0] c);
      req_item_type it;
      it.ch = c;
      it.eot = 1'b0;
      pending_q.push_back(it);
   endtask

   task automatic push_end();
      req_item_type it;
      it.ch = 8'($urandom_range(0, 255));
      it.eot = 1'b1;
      pending_q.push_back(it);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i]);
   endtask

   task automatic push_letter();
      if ($urandom_range(0, 3) == 0)
         push_byte(8'($urandom_range(CH_UA, CH_UZ)));
      else
         push_byte(8'($urandom_range(CH_LA, CH_LZ)));
   endtask

   task automatic gen_ws();
      int n;
      n = ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(1, 2);
      repeat (n) push_byte(blank_set[$urandom_range(0, 5)]);
   endtask

   task automatic gen_string();
      int n;
      int sel;
      logic [7:0] c;
      push_byte(CH_QUOTE);
      n = $urandom_range(0, 8);
      repeat (n) begin
         sel = $urandom_range(0, 99);
         if (sel < 80 && sel >= 65) begin
            push_byte(CH_BSLASH);
            push_byte(esc_set[$urandom_range(0, 7)]);
         end else if (sel >= 95) begin
            // mostly an illegal escape
            push_byte(CH_BSLASH);
            push_byte(8'($urandom_range(0, 255)));
         end else begin
            c = (sel < 65) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
            if (c == CH_QUOTE || c == CH_BSLASH)
               c = CH_SUB;
            push_byte(c);
         end
      end
      if ($urandom_range(0, 99) < 97)
         push_byte(CH_QUOTE);
   endtask

   task automatic gen_number();
      int n;
      push_byte(($urandom_range(0, 4) == 0) ? CH_MINUS : num_set[$urandom_range(0, 9)]);
      n = $urandom_range(0, 5);
      repeat (n) push_byte(num_set[$urandom_range(0, 14)]);
   endtask

   task automatic gen_word();
      int k;
      string w;
      k = $urandom_range(0, 2);
      w = kw_word[k];
      if ($urandom_range(0, 99) < 80) begin
         push_text(w);
      end else begin
         case ($urandom_range(0, 2))
            0: push_text(w.substr(0, $urandom_range(0, w.len() - 2)));
            1: begin
               push_text(w);
               push_letter();
            end
            default: repeat ($urandom_range(1, 6)) push_letter();
         endcase
      end
   endtask

   task automatic gen_value(input int depth);
      int sel;
      int m;
      sel = $urandom_range(0, 99);
      if (depth < 3 && sel < 15) begin
         push_byte(CH_LBRACE);
         gen_ws();
         m = $urandom_range(0, 3);
         for (int j = 0; j < m; j++) begin
            if (j > 0) begin
               push_byte(CH_COMMA);
               gen_ws();
            end
            gen_string();
            gen_ws();
            push_byte(CH_COLON);
            gen_ws();
            gen_value(depth + 1);
            gen_ws();
         end
         push_byte(CH_RBRACE);
      end else if (depth < 3 && sel < 30) begin
         push_byte(CH_LBRACK);
         gen_ws();
         m = $urandom_range(0, 4);
         for (int j = 0; j < m; j++) begin
            if (j > 0) begin
               push_byte(CH_COMMA);
               gen_ws();
            end
            gen_value(depth + 1);
            gen_ws();
         end
         push_byte(CH_RBRACK);
      end else if (sel < 55) begin
         gen_string();
      end else if (sel < 75) begin
         gen_number();
      end else if (sel < 93) begin
         gen_word();
      end else begin
         repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            scan_request(on_bus);
            taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_q.size() > 0 &&
                ((taken >= 500 && taken < 800) || $urandom_range(0, 99) >= 13)) begin
               on_bus = pending_q.pop_front();
               req_valid <= 1'b1;
               req_in_byte <= on_bus.ch;
               req_end_of_text <= on_bus.eot;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cyc++;
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (tokens_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected result kind %0d char %0d/%02h",
                                       rsp_token_kind, rsp_char_valid, rsp_char_out));
            end else begin
               want = tokens_due.pop_front();
               if (rsp_token_kind !== want.tok.kind)
                  flag_mismatch($sformatf("token_kind got %0d want %0d",
                                          rsp_token_kind, want.tok.kind));
               if (rsp_char_valid !== want.tok.cv)
                  flag_mismatch($sformatf("char_valid got %0b want %0b",
                                          rsp_char_valid, want.tok.cv));
               if (rsp_char_out !== want.tok.ch)
                  flag_mismatch($sformatf("char_out got %02h want %02h",
                                          rsp_char_out, want.tok.ch));
               if (rsp_last_of_run !== want.last)
                  flag_mismatch($sformatf("last_of_run got %0b want %0b",
                                          rsp_last_of_run, want.last));
            end
         end
         // long hold-off so the result queue backs up into req_stall
         if (cyc == 400 || cyc == 3000)
            hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !(results_seen >= 500 && results_seen < 800) &&
                         ($urandom_range(0, 99) < 13);
         end
      end
   end

   // ---------------- watchdog ----------------

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("tb_json_token_scanner NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int base;
      int sel;

      // punctuation with blanks between
      push_text("{ }[");
      push_byte(CH_TAB);
      push_text("]:,");
      // escaped slash, then an illegal escape
      push_text("\"\\/\\q");
      // loose number closed by a brace: two results from one byte
      push_text("-.e+E9}");
      // too-short identifier flushed by end
      push_text("nul");
      push_end();
      // open string at end, then bytes that start nothing
      push_text("\"a");
      push_end();
      push_byte(8'hFF);
      push_byte(8'h00);

      // lexeme length limit: an escape fills the string exactly, the next byte overflows
      push_byte(CH_QUOTE);
      repeat (LEX_MAX - 2) push_byte(8'($urandom_range(CH_LA, CH_LZ)));
      push_byte(CH_BSLASH);
      push_byte(CH_LN);
      push_byte(CH_LA);
      push_end();

      base = pending_q.size();
      while (pending_q.size() - base < N_RANDOM) begin
         gen_ws();
         gen_value(0);
         gen_ws();
         sel = $urandom_range(0, 99);
         if (sel < 55)
            push_end();
         else if (sel < 65)
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      end
      push_end();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() > 0 || req_valid) @(posedge clock);
      while (tokens_due.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0)
         $display("tb_json_token_scanner OK");
      else
         $display("tb_json_token_scanner NOT OK");
      $finish;
   end

endmodule

[filelist.f]
src/jts_pkg.sv
src/jts_scan.sv
src/jts_fifo.sv
src/json_token_scanner.sv
src/jts_checker.sv
dv/tb_json_token_scanner.sv
